FILE: src/lru_pr_pkg.sv
package lru_pr_pkg;

    localparam int PAGE_W         = 12;
    localparam int FRAME_IDX_W    = 4;
    localparam int FAULT_W        = 32;
    localparam int FRAMES_DEF     = 16;
    localparam int PAGE_COUNT_DEF = 4096;

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [FAULT_W-1:0]     fault_count;
    } result_t;

endpackage

FILE: src/lru_pr_table.sv
module lru_pr_table #(
    parameter int FRAMES = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] waddr,
    input  logic [lru_pr_pkg::PAGE_W-1:0]                 wpage,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] wage,
    input  logic                                          re,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] raddr,
    output logic [lru_pr_pkg::PAGE_W-1:0]                 rpage,
    output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] rage
);
    import lru_pr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int EW = PAGE_W + IW;

    logic [EW-1:0] mem [FRAMES];
    logic [EW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wpage, wage};
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rpage = rdata_reg[EW-1:IW];
    assign rage  = rdata_reg[IW-1:0];

endmodule

FILE: src/lru_pr_ctrl.sv
module lru_pr_ctrl #(
    parameter int FRAMES     = 16,
    parameter int PAGE_COUNT = 4096
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic [lru_pr_pkg::PAGE_W-1:0]                 page_number,
    output logic                                          mem_we,
    output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] mem_waddr,
    output logic [lru_pr_pkg::PAGE_W-1:0]                 mem_wpage,
    output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] mem_wage,
    output logic                                          mem_re,
    output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] mem_raddr,
    input  logic [lru_pr_pkg::PAGE_W-1:0]                 mem_rpage,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] mem_rage,
    output logic                                          res_valid,
    input  logic                                          res_ready,
    output lru_pr_pkg::result_t                           res
);
    import lru_pr_pkg::*;

    localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW0 = $clog2(FRAMES + 1);
    localparam int CW  = (CW0 > 4) ? CW0 : 4;
    localparam logic [PAGE_W-1:0] PC_LOW = PAGE_W'(PAGE_COUNT);
    localparam int REDUCE_CYCLES = 2;
    localparam int RS  = PAGE_W + $clog2(PAGE_COUNT);
    localparam int RW  = PAGE_W + 2;
    localparam int PW  = PAGE_W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RS) + 64'(PAGE_COUNT) - 64'd1) / 64'(PAGE_COUNT));

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg;
    logic [PAGE_W-1:0]    in_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [PAGE_W-1:0]    quot_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic                 rd_pending_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 hit_found_reg;
    logic [IW-1:0]        hit_slot_reg;
    logic [IW-1:0]        hit_age_reg;
    logic                 empty_found_reg;
    logic [IW-1:0]        empty_slot_reg;
    logic [IW-1:0]        old_slot_reg;
    logic [IW-1:0]        old_age_reg;
    logic [PAGE_W-1:0]    old_page_reg;
    logic [FAULT_W-1:0]   fault_reg;

    logic                 accept;
    logic                 reduce_last;
    logic                 pass_last;
    logic [PW-1:0]        product;
    logic [PAGE_W-1:0]    quot;
    logic [IW-1:0]        slot;
    logic                 evict;
    logic                 rd_valid;
    logic                 is_slot;

    assign accept      = in_valid && !in_stall;
    assign reduce_last = (cnt_reg == CW'(REDUCE_CYCLES - 1));
    assign pass_last   = (cnt_reg == CW'(FRAMES));
    assign product     = PW'(in_reg) * PW'(RECIP);
    assign quot        = PAGE_W'(product >> RS);
    assign evict       = !hit_found_reg && !empty_found_reg;
    assign slot        = hit_found_reg ? hit_slot_reg
                       : (empty_found_reg ? empty_slot_reg : old_slot_reg);
    assign rd_valid    = valid_reg[rd_idx_reg];
    assign is_slot     = (rd_idx_reg == slot);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (reduce_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (pass_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        res_valid = (state_reg == ST_FINISH);
        mem_re    = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE))
                    && (cnt_reg < CW'(FRAMES));
        mem_raddr = cnt_reg[IW-1:0];
        mem_waddr = rd_idx_reg;
        mem_we    = (state_reg == ST_UPDATE) && rd_pending_reg
                    && (is_slot || (rd_valid
                        && (!hit_found_reg || (mem_rage < hit_age_reg))));
        mem_wpage = is_slot ? page_reg : mem_rpage;
        mem_wage  = is_slot ? '0 : IW'(mem_rage + 1'b1);

        res.hit           = hit_found_reg;
        res.frame_index   = FRAME_IDX_W'(slot);
        res.evicted_valid = evict;
        res.evicted_page  = evict ? old_page_reg : '0;
        res.fault_count   = fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            rd_pending_reg <= 1'b0;
            fault_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= mem_re;

            priority case (1'b1)
                accept:                     cnt_reg <= '0;
                (state_reg == ST_REDUCE):   cnt_reg <= reduce_last ? '0 : cnt_reg + 1'b1;
                (state_reg == ST_SCAN):     cnt_reg <= pass_last ? '0 : cnt_reg + 1'b1;
                (state_reg == ST_UPDATE):   cnt_reg <= pass_last ? '0 : cnt_reg + 1'b1;
                default:                    cnt_reg <= cnt_reg;
            endcase

            if ((state_reg == ST_UPDATE) && pass_last)
            begin
                valid_reg[slot] <= 1'b1;
                if (!hit_found_reg && (fault_reg != FAULT_MAX))
                begin
                    fault_reg <= fault_reg + 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= mem_raddr;

        if (accept)
        begin
            in_reg          <= page_number;
            page_reg        <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end

        // page modulo the page count: reciprocal multiply, then subtract
        if (state_reg == ST_REDUCE)
        begin
            if (reduce_last)
            begin
                page_reg <= in_reg - quot_reg * PC_LOW;
            end
            else
            begin
                quot_reg <= quot;
            end
        end

        if ((state_reg == ST_SCAN) && rd_pending_reg)
        begin
            if (rd_valid && (mem_rpage == page_reg) && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_slot_reg  <= rd_idx_reg;
                hit_age_reg   <= mem_rage;
            end
            if (!rd_valid && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_slot_reg  <= rd_idx_reg;
            end
            if ((rd_idx_reg == '0) || (rd_valid && (mem_rage > old_age_reg)))
            begin
                old_slot_reg <= rd_idx_reg;
                old_age_reg  <= mem_rage;
                old_page_reg <= mem_rpage;
            end
        end
    end

endmodule

FILE: src/lru_page_replacement.sv
// each accepted reference runs the page reduction, then two passes over the frame
// memory, one entry per cycle on its read port: lookup, then age update; a new
// reference is taken only once the result of the last one has been handed on
// reset: all frames empty and fault count zero at once, no clearing pass
module lru_page_replacement #(
    parameter int FRAMES     = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_COUNT = lru_pr_pkg::PAGE_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [lru_pr_pkg::PAGE_W-1:0]         page_number,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit,
    output logic [lru_pr_pkg::FRAME_IDX_W-1:0]    frame_index,
    output logic                                  evicted_valid,
    output logic [lru_pr_pkg::PAGE_W-1:0]         evicted_page,
    output logic [lru_pr_pkg::FAULT_W-1:0]        fault_count
);
    import lru_pr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [PAGE_W-1:0] mem_wpage;
    logic [IW-1:0]     mem_wage;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;
    logic [PAGE_W-1:0] mem_rpage;
    logic [IW-1:0]     mem_rage;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              out_valid_reg;
    result_t           out_reg;

    lru_pr_ctrl #(
        .FRAMES     (FRAMES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .page_number (page_number),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wpage   (mem_wpage),
        .mem_wage    (mem_wage),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rpage   (mem_rpage),
        .mem_rage    (mem_rage),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    lru_pr_table #(
        .FRAMES (FRAMES)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wpage (mem_wpage),
        .wage  (mem_wage),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rpage (mem_rpage),
        .rage  (mem_rage)
    );

    // output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_reg.hit;
    assign frame_index   = out_reg.frame_index;
    assign evicted_valid = out_reg.evicted_valid;
    assign evicted_page  = out_reg.evicted_page;
    assign fault_count   = out_reg.fault_count;

endmodule

FILE: src/lru_pr_checker.sv
module lru_pr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               hit,
    input logic                               evicted_valid,
    input logic [lru_pr_pkg::PAGE_W-1:0]      evicted_page,
    input logic [lru_pr_pkg::FAULT_W-1:0]     fault_count
);
    import lru_pr_pkg::*;

    // one reference at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a reference is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (hit || !evicted_valid)) |-> (evicted_page == '0)
            && !(hit && evicted_valid))
        else $error("eviction reported without a replacement");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (fault_count != '0))
        else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement lru_pr_checker u_lru_pr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
);

FILE: tb/lru_page_replacement_tb.sv
module lru_page_replacement_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pr_pkg::*;

    localparam int NUM_FRAMES     = FRAMES_DEF;
    localparam int RANDOM_REFS    = 530;
    localparam int LATENCY        = 2 * NUM_FRAMES + 5;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [PAGE_W-1:0]      page;
        bit                     fixed;
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   ev_valid;
        logic [PAGE_W-1:0]      ev_page;
        logic [FAULT_W-1:0]     faults;
    } ref_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [PAGE_W-1:0]      page_number = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_count;

    // lru predictor state
    logic [PAGE_W-1:0]  lru_page  [NUM_FRAMES];
    bit                 lru_valid [NUM_FRAMES];
    int unsigned        lru_age   [NUM_FRAMES];
    logic [FAULT_W-1:0] lru_faults;

    result_t     expected_results [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic [PAGE_W-1:0] page_pool [$];

    // fill from empty, first full eviction, then recency shuffles
    ref_row_t directed_refs [0:21] = '{
        '{12'h000, 1'b1, 1'b0, 4'd0,  1'b0, 12'h000, 32'd1},
        '{12'hfff, 1'b1, 1'b0, 4'd1,  1'b0, 12'h000, 32'd2},
        '{12'h000, 1'b1, 1'b1, 4'd0,  1'b0, 12'h000, 32'd2},
        '{12'h001, 1'b1, 1'b0, 4'd2,  1'b0, 12'h000, 32'd3},
        '{12'h002, 1'b1, 1'b0, 4'd3,  1'b0, 12'h000, 32'd4},
        '{12'h004, 1'b1, 1'b0, 4'd4,  1'b0, 12'h000, 32'd5},
        '{12'h008, 1'b1, 1'b0, 4'd5,  1'b0, 12'h000, 32'd6},
        '{12'h010, 1'b1, 1'b0, 4'd6,  1'b0, 12'h000, 32'd7},
        '{12'h020, 1'b1, 1'b0, 4'd7,  1'b0, 12'h000, 32'd8},
        '{12'h040, 1'b1, 1'b0, 4'd8,  1'b0, 12'h000, 32'd9},
        '{12'h080, 1'b1, 1'b0, 4'd9,  1'b0, 12'h000, 32'd10},
        '{12'h100, 1'b1, 1'b0, 4'd10, 1'b0, 12'h000, 32'd11},
        '{12'h200, 1'b1, 1'b0, 4'd11, 1'b0, 12'h000, 32'd12},
        '{12'h400, 1'b1, 1'b0, 4'd12, 1'b0, 12'h000, 32'd13},
        '{12'h800, 1'b1, 1'b0, 4'd13, 1'b0, 12'h000, 32'd14},
        '{12'haaa, 1'b1, 1'b0, 4'd14, 1'b0, 12'h000, 32'd15},
        '{12'h555, 1'b1, 1'b0, 4'd15, 1'b0, 12'h000, 32'd16},
        '{12'h123, 1'b1, 1'b0, 4'd1,  1'b1, 12'hfff, 32'd17},
        '{12'h000, 1'b0, 1'b0, 4'd0,  1'b0, 12'h000, 32'd0},
        '{12'h456, 1'b0, 1'b0, 4'd0,  1'b0, 12'h000, 32'd0},
        '{12'h123, 1'b0, 1'b0, 4'd0,  1'b0, 12'h000, 32'd0},
        '{12'hfff, 1'b0, 1'b0, 4'd0,  1'b0, 12'h000, 32'd0}
    };

    lru_page_replacement u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    always #5 clk = ~clk;

    function automatic result_t lru_reference(input logic [PAGE_W-1:0] page);
        result_t     r;
        int          slot;
        int unsigned oldest;
        int unsigned limit;
        r = '0;
        slot = -1;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (slot < 0 && lru_valid[i] && lru_page[i] == page)
                slot = i;
        end
        if (slot >= 0)
        begin
            r.hit = 1'b1;
            limit = lru_age[slot];
        end
        else
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                if (slot < 0 && !lru_valid[i])
                    slot = i;
            end
            if (slot < 0)
            begin
                oldest = 0;
                slot = 0;
                for (int i = 0; i < NUM_FRAMES; i++)
                begin
                    if (lru_age[i] > oldest)
                    begin
                        oldest = lru_age[i];
                        slot = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = lru_page[slot];
            end
            limit = 32'hffff_ffff;
        end
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (i != slot && lru_valid[i] && lru_age[i] < limit)
                lru_age[i] = lru_age[i] + 1;
        end
        if (!r.hit)
        begin
            lru_page[slot] = page;
            lru_valid[slot] = 1'b1;
            if (lru_faults != FAULT_MAX)
                lru_faults = lru_faults + 1;
        end
        lru_age[slot] = 0;
        r.frame_index = slot[FRAME_IDX_W-1:0];
        r.fault_count = lru_faults;
        return r;
    endfunction

    // random bursts of back-to-back transactions separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_reference(input logic [PAGE_W-1:0] page, input bit fixed,
                                  input result_t fixed_result);
        result_t predicted;
        in_valid <= 1'b1;
        page_number <= page;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = lru_reference(page);
        expected_results.push_back(fixed ? fixed_result : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall stretches of random length and polarity
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= $urandom_range(0, 24);
            out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.hit = hit;
            got.frame_index = frame_index;
            got.evicted_valid = evicted_valid;
            got.evicted_page = evicted_page;
            got.fault_count = fault_count;
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected hit=%b frame=%0d ev=%b/%h faults=%0d",
                             $realtime, got.hit, got.frame_index, got.evicted_valid,
                             got.evicted_page, got.fault_count);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
                    got.evicted_valid !== want.evicted_valid ||
                    got.evicted_page !== want.evicted_page ||
                    got.fault_count !== want.fault_count)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: exp hit=%b frame=%0d ev=%b/%h faults=%0d",
                                 $realtime, want.hit, want.frame_index,
                                 want.evicted_valid, want.evicted_page,
                                 want.fault_count);
                        $display("    got hit=%b frame=%0d ev=%b/%h faults=%0d",
                                 got.hit, got.frame_index, got.evicted_valid,
                                 got.evicted_page, got.fault_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** lru_page_replacement: FAILED **");
            $finish;
        end
    end

    initial
    begin
        result_t           want;
        logic [PAGE_W-1:0] page;
        int                pick;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            lru_page[i] = '0;
            lru_valid[i] = 1'b0;
            lru_age[i] = 0;
        end
        lru_faults = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_refs[i])
        begin
            pace();
            want.hit = directed_refs[i].hit;
            want.frame_index = directed_refs[i].frame;
            want.evicted_valid = directed_refs[i].ev_valid;
            want.evicted_page = directed_refs[i].ev_page;
            want.fault_count = directed_refs[i].faults;
            send_reference(directed_refs[i].page, directed_refs[i].fixed, want);
        end
        drain_results();

        // working sets of varying size: small ones mostly hit, large ones thrash
        page = '0;
        for (int n = 0; n < RANDOM_REFS; n++)
        begin
            if (n % 80 == 0)
            begin
                page_pool.delete();
                repeat ($urandom_range(6, 26))
                    page_pool.push_back(PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1)));
            end
            if (n == RANDOM_REFS / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                page = page_pool[$urandom_range(0, page_pool.size() - 1)];
            else if (pick >= 80)
                page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
            pace();
            send_reference(page, 1'b0, '0);
        end

        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** lru_page_replacement: PASSED **");
        else
            $display("** lru_page_replacement: FAILED **");
        $finish;
    end

endmodule

FILE: lru_page_replacement.f
src/lru_pr_pkg.sv
src/lru_pr_table.sv
src/lru_pr_ctrl.sv
src/lru_page_replacement.sv
src/lru_pr_checker.sv
tb/lru_page_replacement_tb.sv
